>>> design/mdu_pkg.sv
// Package for the multiply/divide unit: operation codes, the pipeline item
// type and small helper functions. No dependencies.
package mdu_pkg;

	localparam logic [2:0] CMD_MUL   = 3'd0;
	localparam logic [2:0] CMD_IMUL1 = 3'd1;
	localparam logic [2:0] CMD_IMUL2 = 3'd2;
	localparam logic [2:0] CMD_DIV   = 3'd3;
	localparam logic [2:0] CMD_IDIV  = 3'd4;

	localparam logic [1:0] OS_BYTE  = 2'd0;
	localparam logic [1:0] OS_WORD  = 2'd1;
	localparam logic [1:0] OS_DWORD = 2'd2;
	localparam logic [1:0] OS_QWORD = 2'd3;

	// One division step per cell.
	localparam int unsigned NUM_CELLS = 64;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [1:0]  os;
		logic [63:0] alo;   // original accumulator
		logic [63:0] ahi;   // original data register
		logic [63:0] rem;   // partial remainder / product high
		logic [63:0] num;   // dividend low bits / multiplicand
		logic [63:0] quo;   // quotient / product low
		logic [63:0] dvs;   // divisor / multiplier
		logic [63:0] pa;    // cross partial products
		logic [63:0] pb;
		logic        nd;    // negative dividend
		logic        nv;    // negative divisor
		logic        ok;    // no divide fault so far
		logic        cf;    // product does not fit
	} item_t;

	function automatic logic [63:0] width_mask(input logic [1:0] os);
		logic [63:0] m;
		case (os)
			OS_BYTE:  m = 64'hff;
			OS_WORD:  m = 64'hffff;
			OS_DWORD: m = 64'hffff_ffff;
			default:  m = '1;
		endcase
		return m;
	endfunction

	// sign-extend from the operand width
	function automatic logic [63:0] sext_os(input logic [63:0] v, input logic [1:0] os);
		logic [63:0] r;
		case (os)
			OS_BYTE:  r = {{56{v[7]}}, v[7:0]};
			OS_WORD:  r = {{48{v[15]}}, v[15:0]};
			OS_DWORD: r = {{32{v[31]}}, v[31:0]};
			default:  r = v;
		endcase
		return r;
	endfunction

	// sign-extend from twice the operand width
	function automatic logic [63:0] sext_dbl(input logic [63:0] v, input logic [1:0] os);
		logic [63:0] r;
		case (os)
			OS_BYTE: r = {{48{v[15]}}, v[15:0]};
			OS_WORD: r = {{32{v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic is_div(input logic [2:0] cmd);
		return (cmd == CMD_DIV) || (cmd == CMD_IDIV);
	endfunction

	function automatic logic is_mul(input logic [2:0] cmd);
		return (cmd == CMD_MUL) || (cmd == CMD_IMUL1) || (cmd == CMD_IMUL2);
	endfunction

endpackage

>>> design/mdu_in_if.sv
// Input channel of the multiply/divide unit: valid/ready plus operation fields.
// No dependencies.
interface mdu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [1:0]  operand_size;
	logic [63:0] source_operand;
	logic [63:0] reg_operand;
	logic [63:0] acc_low_in;
	logic [63:0] acc_high_in;

	modport source (output valid, command, operand_size, source_operand, reg_operand,
		acc_low_in, acc_high_in, input ready);
	modport sink (input valid, command, operand_size, source_operand, reg_operand,
		acc_low_in, acc_high_in, output ready);
endinterface

>>> design/mdu_out_if.sv
// Output channel of the multiply/divide unit: valid/ready plus result fields.
// No dependencies.
interface mdu_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] acc_low_out;
	logic [63:0] acc_high_out;
	logic [63:0] reg_result;
	logic        carry_overflow;
	logic        flags_written;
	logic        divide_error;

	modport source (output valid, acc_low_out, acc_high_out, reg_result, carry_overflow,
		flags_written, divide_error, input ready);
	modport sink (input valid, acc_low_out, acc_high_out, reg_result, carry_overflow,
		flags_written, divide_error, output ready);
endinterface

>>> design/multiply_divide_unit.sv
// Multiply/divide unit for x86-style MUL, IMUL (one and two operand), DIV and
// IDIV at byte, word, doubleword and quadword size. It takes one operation per
// cycle and delivers results in order through four front stages (decode; sign
// handling and 32x32 partial products; product fold; sign correction), a chain
// of 64 division cells that each retire one quotient bit, one back stage and the
// output register. Depth is set by the 64-cell divider chain, which every
// operation passes through so order is kept. When the output register holds a
// result that is not taken, the whole pipeline holds; otherwise a new transfer
// is accepted every cycle.
// Depends on mdu_pkg, mdu_in_if, mdu_out_if, mdu_front, mdu_cell, mdu_back.
module multiply_divide_unit (
	input  logic      clk,
	input  logic      arst_n,
	mdu_in_if.sink    in_ch,
	mdu_out_if.source out_ch
);
	logic en;
	logic           vld [mdu_pkg::NUM_CELLS + 1];
	mdu_pkg::item_t itm [mdu_pkg::NUM_CELLS + 1];

	// decode and multiply
	mdu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ch  (in_ch),
		.vld    (vld[0]),
		.item   (itm[0])
	);

	// divider chain: advance one quotient bit per cell
	for (genvar i = 0; i < mdu_pkg::NUM_CELLS; i++) begin : g_cell
		mdu_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (vld[i]),
			.item_in  (itm[i]),
			.vld_out  (vld[i + 1]),
			.item_out (itm[i + 1])
		);
	end

	// fix-up, layout and output register
	mdu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld[mdu_pkg::NUM_CELLS]),
		.item_in (itm[mdu_pkg::NUM_CELLS]),
		.en      (en),
		.out_ch  (out_ch)
	);

	// a divide fault writes no flags and no register result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.divide_error |->
		!out_ch.flags_written && !out_ch.carry_overflow && out_ch.reg_result == '0)
		else $error("divide fault with flag or register write");

	// overflow is only reported by multiplies
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.carry_overflow |-> out_ch.flags_written)
		else $error("carry set without flag write");

	// a stalled result is not replaced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.acc_low_out))
		else $error("stalled result lost");
endmodule

>>> design/mdu_front.sv
// Front stages: operand decode, sign handling and the 64x64 multiply in
// 32x32 partial products. Depends on mdu_pkg and mdu_in_if.
module mdu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	mdu_in_if.sink         in_ch,
	output logic           vld,
	output mdu_pkg::item_t item
);
	mdu_pkg::item_t d1, d2, d3, d4;
	mdu_pkg::item_t it_s1, it_s2, it_s3, it_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [63:0] mask, a, dlo, dhi;
	logic [127:0] negd;
	logic [33:0] mid;
	logic sgn;

	// decode
	always_comb begin
		mask = mdu_pkg::width_mask(in_ch.operand_size);
		d1 = '0;
		d1.cmd = in_ch.command;
		d1.os = in_ch.operand_size;
		d1.alo = in_ch.acc_low_in;
		d1.ahi = in_ch.acc_high_in;
		d1.ok = 1'b1;
		a = (in_ch.command == mdu_pkg::CMD_IMUL2) ? in_ch.reg_operand : in_ch.acc_low_in;
		dhi = '0;
		case (in_ch.operand_size)
			mdu_pkg::OS_BYTE:  dlo = {48'd0, in_ch.acc_low_in[15:0]};
			mdu_pkg::OS_WORD:  dlo = {32'd0, in_ch.acc_high_in[15:0], in_ch.acc_low_in[15:0]};
			mdu_pkg::OS_DWORD: dlo = {in_ch.acc_high_in[31:0], in_ch.acc_low_in[31:0]};
			default: begin
				dlo = in_ch.acc_low_in;
				dhi = in_ch.acc_high_in;
			end
		endcase
		if (in_ch.command == mdu_pkg::CMD_MUL) begin
			d1.num = in_ch.acc_low_in & mask;
			d1.dvs = in_ch.source_operand & mask;
		end else if (in_ch.command == mdu_pkg::CMD_IDIV) begin
			if (in_ch.operand_size != mdu_pkg::OS_QWORD) begin
				dlo = mdu_pkg::sext_dbl(dlo, in_ch.operand_size);
				dhi = {64{dlo[63]}};
			end
			d1.num = dlo;
			d1.rem = dhi;
			d1.dvs = mdu_pkg::sext_os(in_ch.source_operand, in_ch.operand_size);
			d1.nd = dhi[63];
			d1.nv = d1.dvs[63];
		end else if (in_ch.command == mdu_pkg::CMD_DIV) begin
			d1.num = dlo;
			d1.rem = dhi;
			d1.dvs = in_ch.source_operand & mask;
		end else begin
			d1.num = mdu_pkg::sext_os(a, in_ch.operand_size);
			d1.dvs = mdu_pkg::sext_os(in_ch.source_operand, in_ch.operand_size);
		end
		d1.ok = (in_ch.source_operand & mask) != '0;
	end

	// magnitudes for divide, partial products for multiply
	always_comb begin
		d2 = it_s1;
		negd = ~{it_s1.rem, it_s1.num} + 128'd1;
		if (mdu_pkg::is_mul(it_s1.cmd)) begin
			d2.quo = 64'(it_s1.num[31:0] * it_s1.dvs[31:0]);
			d2.pa  = 64'(it_s1.num[31:0] * it_s1.dvs[63:32]);
			d2.pb  = 64'(it_s1.num[63:32] * it_s1.dvs[31:0]);
			d2.rem = 64'(it_s1.num[63:32] * it_s1.dvs[63:32]);
		end else begin
			if (it_s1.nd) {d2.rem, d2.num} = negd;
			if (it_s1.nv) d2.dvs = ~it_s1.dvs + 64'd1;
		end
	end

	// fold partial products; range check of the dividend high half
	always_comb begin
		d3 = it_s2;
		mid = 34'(it_s2.quo[63:32]) + 34'(it_s2.pa[31:0]) + 34'(it_s2.pb[31:0]);
		if (mdu_pkg::is_mul(it_s2.cmd)) begin
			d3.quo = {mid[31:0], it_s2.quo[31:0]};
			d3.rem = it_s2.rem + 64'(it_s2.pa[63:32]) + 64'(it_s2.pb[63:32])
				+ 64'(mid[33:32]);
		end else begin
			d3.ok = it_s2.ok && (it_s2.rem < it_s2.dvs);
		end
	end

	// signed correction of the product high half
	always_comb begin
		d4 = it_s3;
		sgn = (it_s3.cmd == mdu_pkg::CMD_IMUL1) || (it_s3.cmd == mdu_pkg::CMD_IMUL2);
		if (sgn) begin
			d4.rem = it_s3.rem - (it_s3.num[63] ? it_s3.dvs : 64'd0)
				- (it_s3.dvs[63] ? it_s3.num : 64'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= d1;
			it_s2 <= d2;
			it_s3 <= d3;
			it_s4 <= d4;
		end
	end

	assign in_ch.ready = en;
	assign vld = v_s4;
	assign item = it_s4;
endmodule

>>> design/mdu_cell.sv
// One restoring division step of the divider chain; other operations pass.
// Depends on mdu_pkg.
module mdu_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  mdu_pkg::item_t item_in,
	output logic           vld_out,
	output mdu_pkg::item_t item_out
);
	mdu_pkg::item_t nxt;
	logic [63:0] shr;
	logic        vld_q;
	mdu_pkg::item_t item_q;

	always_comb begin
		nxt = item_in;
		shr = {item_in.rem[62:0], item_in.num[63]};
		if (mdu_pkg::is_div(item_in.cmd)) begin
			nxt.num = {item_in.num[62:0], 1'b0};
			if (item_in.rem[63] || shr >= item_in.dvs) begin
				nxt.rem = shr - item_in.dvs;
				nxt.quo = {item_in.quo[62:0], 1'b1};
			end else begin
				nxt.rem = shr;
				nxt.quo = {item_in.quo[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign vld_out = vld_q;
	assign item_out = item_q;
endmodule

>>> design/mdu_back.sv
// Back stages: quotient range check, sign fix-up, overflow flag and the
// register layout, ending in the output register. Depends on mdu_pkg, mdu_out_if.
module mdu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  mdu_pkg::item_t item_in,
	output logic           en,
	mdu_out_if.source      out_ch
);
	mdu_pkg::item_t d1, it_s1;
	logic v_s1, out_vld_q;
	logic [63:0] mask, lim, alo, ahi, reg_r;
	logic nq, cf, fw, de;
	logic [63:0] acc_lo_q, acc_hi_q, reg_q;
	logic cf_q, fw_q, de_q;

	assign en = !out_vld_q || out_ch.ready;

	always_comb begin
		d1 = item_in;
		mask = mdu_pkg::width_mask(item_in.os);
		nq = item_in.nd ^ item_in.nv;
		case (item_in.os)
			mdu_pkg::OS_BYTE:  lim = 64'h80;
			mdu_pkg::OS_WORD:  lim = 64'h8000;
			mdu_pkg::OS_DWORD: lim = 64'h8000_0000;
			default:           lim = 64'h8000_0000_0000_0000;
		endcase
		d1.cf = 1'b0;
		if (item_in.cmd == mdu_pkg::CMD_DIV) begin
			if (item_in.os != mdu_pkg::OS_QWORD && (item_in.quo & ~mask) != '0) d1.ok = 1'b0;
		end else if (item_in.cmd == mdu_pkg::CMD_IDIV) begin
			if (nq ? (item_in.quo > lim) : (item_in.quo >= lim)) d1.ok = 1'b0;
			if (nq) d1.quo = ~item_in.quo + 64'd1;
			if (item_in.nd) d1.rem = ~item_in.rem + 64'd1;
		end else if (item_in.cmd == mdu_pkg::CMD_MUL) begin
			// product bits above the operand width
			d1.cf = (item_in.os == mdu_pkg::OS_QWORD) ? (item_in.rem != '0)
				: ((item_in.quo & ~mask) != '0);
		end else if (mdu_pkg::is_mul(item_in.cmd)) begin
			d1.cf = (item_in.os == mdu_pkg::OS_QWORD) ? (item_in.rem != {64{item_in.quo[63]}})
				: (item_in.quo != mdu_pkg::sext_os(item_in.quo, item_in.os));
		end
	end

	// merge results into the register layout
	always_comb begin
		alo = it_s1.alo;
		ahi = it_s1.ahi;
		reg_r = '0;
		cf = 1'b0;
		fw = 1'b0;
		de = 1'b0;
		if (mdu_pkg::is_mul(it_s1.cmd)) begin
			fw = 1'b1;
			cf = it_s1.cf;
			if (it_s1.cmd == mdu_pkg::CMD_IMUL2) begin
				reg_r = it_s1.quo & mdu_pkg::width_mask(it_s1.os);
			end else begin
				case (it_s1.os)
					mdu_pkg::OS_BYTE: alo = {it_s1.alo[63:16], it_s1.quo[15:0]};
					mdu_pkg::OS_WORD: begin
						alo = {it_s1.alo[63:16], it_s1.quo[15:0]};
						ahi = {it_s1.ahi[63:16], it_s1.quo[31:16]};
					end
					mdu_pkg::OS_DWORD: begin
						alo = {32'd0, it_s1.quo[31:0]};
						ahi = {32'd0, it_s1.quo[63:32]};
					end
					default: begin
						alo = it_s1.quo;
						ahi = it_s1.rem;
					end
				endcase
			end
		end else if (mdu_pkg::is_div(it_s1.cmd)) begin
			if (!it_s1.ok) begin
				de = 1'b1;
			end else begin
				case (it_s1.os)
					mdu_pkg::OS_BYTE: alo = {it_s1.alo[63:16], it_s1.rem[7:0], it_s1.quo[7:0]};
					mdu_pkg::OS_WORD: begin
						alo = {it_s1.alo[63:16], it_s1.quo[15:0]};
						ahi = {it_s1.ahi[63:16], it_s1.rem[15:0]};
					end
					mdu_pkg::OS_DWORD: begin
						alo = {32'd0, it_s1.quo[31:0]};
						ahi = {32'd0, it_s1.rem[31:0]};
					end
					default: begin
						alo = it_s1.quo;
						ahi = it_s1.rem;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			out_vld_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= d1;
			acc_lo_q <= alo;
			acc_hi_q <= ahi;
			reg_q <= reg_r;
			cf_q <= cf;
			fw_q <= fw;
			de_q <= de;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.acc_low_out = acc_lo_q;
	assign out_ch.acc_high_out = acc_hi_q;
	assign out_ch.reg_result = reg_q;
	assign out_ch.carry_overflow = cf_q;
	assign out_ch.flags_written = fw_q;
	assign out_ch.divide_error = de_q;
endmodule
